// ===== src/text_cell_rect_draw_engine_assert.svh =====
// Assertion macros shared by the draw engine modules.
`ifndef TEXT_CELL_RECT_DRAW_ENGINE_ASSERT_SVH
`define TEXT_CELL_RECT_DRAW_ENGINE_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define TCR_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("draw engine check failed");
`define TCR_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("draw engine check failed");
`else
`define TCR_ASSERT(label, prop)
`define TCR_ASSERT_IMPL(label, ante, cons)
`endif

`endif

// ===== src/tcr_pkg.sv =====
package tcr_pkg;

  localparam int COORD_W = 9;

  localparam logic [7:0] GL_SPACE     = 8'h20;
  localparam logic [7:0] GL_HORIZ     = 8'hC4;
  localparam logic [7:0] GL_VERT      = 8'hB3;
  localparam logic [7:0] GL_TOP_LEFT  = 8'hDA;
  localparam logic [7:0] GL_TOP_RIGHT = 8'hBF;
  localparam logic [7:0] GL_BOT_LEFT  = 8'hC0;
  localparam logic [7:0] GL_BOT_RIGHT = 8'hD9;
  localparam logic [7:0] GL_BLOCK     = 8'hDB;
  localparam logic [7:0] GL_SHADE     = 8'hB0;
  localparam logic [7:0] ATTR_CURSOR  = 8'h0F;
  localparam logic [7:0] ATTR_SHADOW  = 8'h08;

  typedef enum logic [2:0] {
    CMD_CLEAR   = 3'd0,
    CMD_FILL    = 3'd1,
    CMD_OUTLINE = 3'd2,
    CMD_SHADOW  = 3'd3,
    CMD_PUT     = 3'd4,
    CMD_CURSOR  = 3'd5,
    CMD_READ    = 3'd6
  } cmd_code_t;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_FILL,
    OP_OUTLINE,
    OP_SHADOW,
    OP_PUT,
    OP_READ
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] w;
    logic [7:0] h;
    logic [7:0] attr;
    logic [7:0] glyph;
  } draw_cmd_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FILL,
    ST_TOP,
    ST_BOT,
    ST_LEFT,
    ST_RIGHT,
    ST_CORNER,
    ST_SHR,
    ST_SHB,
    ST_PUT,
    ST_READ,
    ST_RDATA,
    ST_DONE
  } back_state_t;

  function automatic logic [7:0] corner_glyph(input logic [1:0] k);
    logic [7:0] g;
    unique case (k)
      2'd0: g = GL_TOP_LEFT;
      2'd1: g = GL_TOP_RIGHT;
      2'd2: g = GL_BOT_LEFT;
      2'd3: g = GL_BOT_RIGHT;
      default: g = GL_TOP_LEFT;
    endcase
    return g;
  endfunction

endpackage

// ===== src/text_cell_rect_draw_engine.sv =====
// Text-cell drawing engine over a SCREEN_COLUMNS x SCREEN_ROWS store of 16-bit cells
// (attribute high byte, glyph low byte). After reset the store is zeroed one cell per
// cycle, with full held high. A command queue of two entries feeds a draw sequencer
// that writes one cell per cycle through the single write port of the screen memory.
// A fill or clear writes its area row by row, clipped to the screen; an outline
// writes the top and bottom edges, then the left and right edges and the four
// corners, and a shadow box adds a shade column at the right and a shade row below.
// Every command yields one result; the sequencer starts a command only once the
// previous result has been popped.
module text_cell_rect_draw_engine #(
  parameter int SCREEN_COLUMNS = 80,
  parameter int SCREEN_ROWS = 25
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  output logic       in_full,
  input  logic [2:0] in_command,
  input  logic [7:0] in_col_x,
  input  logic [7:0] in_row_y,
  input  logic [7:0] in_width,
  input  logic [7:0] in_height,
  input  logic [3:0] in_ink_color,
  input  logic [3:0] in_paper_color,
  input  logic [7:0] in_glyph,
  input  logic       in_visible,
  output logic       out_empty,
  input  logic       out_pop,
  output logic [7:0] out_read_glyph,
  output logic [7:0] out_read_attr,
  output logic       out_read_valid
);

  import tcr_pkg::*;

  logic      q_full, q_empty, q_pop, q_push;
  logic      clearing, out_full;
  draw_cmd_t q_head;

  assign in_full   = q_full || clearing;
  assign q_push    = in_push && !in_full;
  assign out_empty = !out_full;

  tcr_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (q_push),
    .command     (in_command),
    .col_x       (in_col_x),
    .row_y       (in_row_y),
    .width       (in_width),
    .height      (in_height),
    .ink_color   (in_ink_color),
    .paper_color (in_paper_color),
    .glyph       (in_glyph),
    .visible     (in_visible),
    .full        (q_full),
    .empty       (q_empty),
    .head        (q_head),
    .pop         (q_pop)
  );

  tcr_back #(
    .SCREEN_COLUMNS (SCREEN_COLUMNS),
    .SCREEN_ROWS    (SCREEN_ROWS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .clearing  (clearing),
    .out_full  (out_full),
    .out_glyph (out_read_glyph),
    .out_attr  (out_read_attr),
    .out_valid (out_read_valid),
    .out_pop   (out_pop)
  );

endmodule

// ===== src/tcr_ram.sv =====
module tcr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000,
  parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

// ===== src/tcr_front.sv =====
`include "text_cell_rect_draw_engine_assert.svh"

module tcr_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  logic [2:0]         command,
  input  logic [7:0]         col_x,
  input  logic [7:0]         row_y,
  input  logic [7:0]         width,
  input  logic [7:0]         height,
  input  logic [3:0]         ink_color,
  input  logic [3:0]         paper_color,
  input  logic [7:0]         glyph,
  input  logic               visible,
  output logic               full,
  output logic               empty,
  output tcr_pkg::draw_cmd_t head,
  input  logic               pop
);

  import tcr_pkg::*;

  draw_cmd_t  mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  draw_cmd_t  dec;
  logic       do_push, do_pop;

  always_comb begin
    dec       = '0;
    dec.x     = col_x;
    dec.y     = row_y;
    dec.w     = width;
    dec.h     = height;
    dec.attr  = {4'h0, ink_color};
    dec.glyph = GL_SPACE;
    unique case (cmd_code_t'(command))
      CMD_CLEAR:   dec.op = OP_FILL;
      CMD_FILL: begin
        dec.op   = OP_FILL;
        dec.attr = {ink_color, ink_color};
      end
      CMD_OUTLINE: dec.op = OP_OUTLINE;
      CMD_SHADOW:  dec.op = OP_SHADOW;
      CMD_PUT: begin
        dec.op    = OP_PUT;
        dec.glyph = glyph;
        dec.attr  = {paper_color, ink_color};
      end
      CMD_CURSOR: begin
        dec.op    = OP_PUT;
        dec.glyph = visible ? GL_BLOCK : GL_SPACE;
        dec.attr  = ATTR_CURSOR;
      end
      CMD_READ:    dec.op = OP_READ;
      default:     dec.op = OP_NOP;
    endcase
  end

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign head    = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= dec;
    end
  end

  `TCR_ASSERT(a_cnt_grow, (do_push && !do_pop) |=> (cnt_r == $past(cnt_r) + 2'd1))

endmodule

// ===== src/tcr_back.sv =====
`include "text_cell_rect_draw_engine_assert.svh"

module tcr_back #(
  parameter int SCREEN_COLUMNS = 80,
  parameter int SCREEN_ROWS = 25
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty,
  input  tcr_pkg::draw_cmd_t q_head,
  output logic               q_pop,
  output logic               clearing,
  output logic               out_full,
  output logic [7:0]         out_glyph,
  output logic [7:0]         out_attr,
  output logic               out_valid,
  input  logic               out_pop
);

  import tcr_pkg::*;

  localparam int DEPTH = SCREEN_COLUMNS * SCREEN_ROWS;
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [COORD_W-1:0] COLS = COORD_W'(SCREEN_COLUMNS);
  localparam logic [COORD_W-1:0] ROWS = COORD_W'(SCREEN_ROWS);
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

  back_state_t        state_r, state_nxt;
  draw_cmd_t          cmd_r, cmd_nxt;
  logic [COORD_W-1:0] col_r, col_nxt;
  logic [COORD_W-1:0] row_r, row_nxt;
  logic [1:0]         k_r, k_nxt;
  logic [AW-1:0]      clr_r, clr_nxt;
  logic               hit_r, hit_nxt;
  logic               out_full_r, out_full_nxt;
  logic [7:0]         out_glyph_r, out_glyph_nxt;
  logic [7:0]         out_attr_r, out_attr_nxt;
  logic               out_valid_r, out_valid_nxt;

  logic [COORD_W-1:0] x9, y9, xe, ye, xr, yb;
  logic [COORD_W-1:0] hx, hy, hw;
  logic [COORD_W-1:0] wcol, wrow;
  logic [7:0]         wglyph, wattr;
  logic               draw_we, clr_we, on_screen, re;
  logic [16:0]        lin;
  logic [AW-1:0]      cell_addr;
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [15:0]        ram_wdata, ram_rdata;

  assign x9 = {1'b0, cmd_r.x};
  assign y9 = {1'b0, cmd_r.y};
  assign xe = x9 + {1'b0, cmd_r.w};
  assign ye = y9 + {1'b0, cmd_r.h};
  assign xr = xe - 9'd1;
  assign yb = ye - 9'd1;
  assign hx = {1'b0, q_head.x};
  assign hy = {1'b0, q_head.y};
  assign hw = {1'b0, q_head.w};

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    k_nxt         = k_r;
    clr_nxt       = clr_r;
    hit_nxt       = hit_r;
    out_full_nxt  = out_full_r;
    out_glyph_nxt = out_glyph_r;
    out_attr_nxt  = out_attr_r;
    out_valid_nxt = out_valid_r;
    q_pop         = 1'b0;
    draw_we       = 1'b0;
    clr_we        = 1'b0;
    re            = 1'b0;
    wcol          = col_r;
    wrow          = row_r;
    wglyph        = GL_SPACE;
    wattr         = cmd_r.attr;

    if (out_pop && out_full_r) begin
      out_full_nxt = 1'b0;
    end

    unique case (state_r)
      ST_CLEAR: begin
        clr_we = 1'b1;
        if (clr_r == LAST_ADDR) begin
          state_nxt = ST_IDLE;
        end else begin
          clr_nxt = clr_r + AW'(1);
        end
      end
      ST_IDLE: begin
        if (!q_empty && !out_full_r) begin
          q_pop   = 1'b1;
          cmd_nxt = q_head;
          col_nxt = hx;
          row_nxt = hy;
          k_nxt   = 2'd0;
          unique case (q_head.op)
            OP_FILL: state_nxt = ST_FILL;
            OP_OUTLINE, OP_SHADOW: begin
              if (q_head.w >= 8'd2 && q_head.h >= 8'd2) begin
                col_nxt   = hx + 9'd1;
                state_nxt = ST_TOP;
              end else if (q_head.op == OP_SHADOW) begin
                col_nxt   = hx + hw;
                row_nxt   = hy + 9'd1;
                state_nxt = ST_SHR;
              end else begin
                state_nxt = ST_DONE;
              end
            end
            OP_PUT:  state_nxt = ST_PUT;
            OP_READ: state_nxt = ST_READ;
            default: state_nxt = ST_DONE;
          endcase
        end
      end
      ST_FILL: begin
        if (row_r < ye && row_r < ROWS) begin
          if (col_r < xe && col_r < COLS) begin
            draw_we = 1'b1;
            col_nxt = col_r + 9'd1;
          end else begin
            col_nxt = x9;
            row_nxt = row_r + 9'd1;
          end
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_TOP: begin
        wglyph = GL_HORIZ;
        if (col_r < xr && col_r < COLS) begin
          draw_we = 1'b1;
          col_nxt = col_r + 9'd1;
        end else begin
          col_nxt   = x9 + 9'd1;
          row_nxt   = yb;
          state_nxt = ST_BOT;
        end
      end
      ST_BOT: begin
        wglyph = GL_HORIZ;
        if (col_r < xr && col_r < COLS) begin
          draw_we = 1'b1;
          col_nxt = col_r + 9'd1;
        end else begin
          col_nxt   = x9;
          row_nxt   = y9 + 9'd1;
          state_nxt = ST_LEFT;
        end
      end
      ST_LEFT: begin
        wglyph = GL_VERT;
        if (row_r < yb && row_r < ROWS) begin
          draw_we = 1'b1;
          row_nxt = row_r + 9'd1;
        end else begin
          col_nxt   = xr;
          row_nxt   = y9 + 9'd1;
          state_nxt = ST_RIGHT;
        end
      end
      ST_RIGHT: begin
        wglyph = GL_VERT;
        if (row_r < yb && row_r < ROWS) begin
          draw_we = 1'b1;
          row_nxt = row_r + 9'd1;
        end else begin
          k_nxt     = 2'd0;
          state_nxt = ST_CORNER;
        end
      end
      ST_CORNER: begin
        draw_we = 1'b1;
        wcol    = k_r[0] ? xr : x9;
        wrow    = k_r[1] ? yb : y9;
        wglyph  = corner_glyph(k_r);
        k_nxt   = k_r + 2'd1;
        if (k_r == 2'd3) begin
          if (cmd_r.op == OP_SHADOW) begin
            col_nxt   = xe;
            row_nxt   = y9 + 9'd1;
            state_nxt = ST_SHR;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_SHR: begin
        wglyph = GL_SHADE;
        wattr  = ATTR_SHADOW;
        if (row_r <= ye && row_r < ROWS) begin
          draw_we = 1'b1;
          row_nxt = row_r + 9'd1;
        end else begin
          col_nxt   = x9 + 9'd1;
          row_nxt   = ye;
          state_nxt = ST_SHB;
        end
      end
      ST_SHB: begin
        wglyph = GL_SHADE;
        wattr  = ATTR_SHADOW;
        if (col_r <= xe && col_r < COLS) begin
          draw_we = 1'b1;
          col_nxt = col_r + 9'd1;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_PUT: begin
        draw_we   = 1'b1;
        wglyph    = cmd_r.glyph;
        state_nxt = ST_DONE;
      end
      ST_READ: begin
        re        = on_screen;
        hit_nxt   = on_screen;
        state_nxt = ST_RDATA;
      end
      ST_RDATA: begin
        out_full_nxt  = 1'b1;
        out_glyph_nxt = hit_r ? ram_rdata[7:0] : 8'h00;
        out_attr_nxt  = hit_r ? ram_rdata[15:8] : 8'h00;
        out_valid_nxt = hit_r;
        state_nxt     = ST_IDLE;
      end
      ST_DONE: begin
        out_full_nxt  = 1'b1;
        out_glyph_nxt = 8'h00;
        out_attr_nxt  = 8'h00;
        out_valid_nxt = 1'b0;
        state_nxt     = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign on_screen = (wcol < COLS) && (wrow < ROWS);
  assign lin       = 17'(wrow[7:0]) * 17'(SCREEN_COLUMNS) + 17'(wcol[7:0]);
  assign cell_addr = lin[AW-1:0];
  assign ram_we    = clr_we || (draw_we && on_screen);
  assign ram_waddr = clr_we ? clr_r : cell_addr;
  assign ram_wdata = clr_we ? 16'h0000 : {wattr, wglyph};

  tcr_ram #(
    .WIDTH (16),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (re),
    .raddr (cell_addr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      clr_r      <= '0;
      out_full_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      clr_r      <= clr_nxt;
      out_full_r <= out_full_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    col_r       <= col_nxt;
    row_r       <= row_nxt;
    k_r         <= k_nxt;
    hit_r       <= hit_nxt;
    out_glyph_r <= out_glyph_nxt;
    out_attr_r  <= out_attr_nxt;
    out_valid_r <= out_valid_nxt;
  end

  assign clearing  = (state_r == ST_CLEAR);
  assign out_full  = out_full_r;
  assign out_glyph = out_glyph_r;
  assign out_attr  = out_attr_r;
  assign out_valid = out_valid_r;

  `TCR_ASSERT_IMPL(a_pop_idle, q_pop, (state_r == ST_IDLE) && !out_full_r)
  `TCR_ASSERT_IMPL(a_waddr_range, ram_we, ram_waddr <= LAST_ADDR)
  `TCR_ASSERT_IMPL(a_nonread_zero, out_full_r && !out_valid_r,
                   (out_glyph_r == 8'h00) && (out_attr_r == 8'h00))

endmodule

// ===== test/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import tcr_pkg::*;

  localparam int COLS = 80;
  localparam int ROWS = 25;
  localparam int CELL_COUNT = COLS * ROWS;
  localparam int CYCLE_LIMIT = 4000000;
  localparam int RANDOM_ITEMS = 300;
  localparam logic [2:0] CMD_UNUSED = 3'd7;

  typedef struct {
    logic [7:0] glyph;
    logic [7:0] attr;
    logic       valid;
  } cell_read_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_push = 1'b0;
  logic       in_full;
  logic [2:0] in_command = CMD_READ;
  logic [7:0] in_col_x = 8'd0;
  logic [7:0] in_row_y = 8'd0;
  logic [7:0] in_width = 8'd0;
  logic [7:0] in_height = 8'd0;
  logic [3:0] in_ink_color = 4'd0;
  logic [3:0] in_paper_color = 4'd0;
  logic [7:0] in_glyph = 8'd0;
  logic       in_visible = 1'b0;
  logic       out_empty;
  logic       out_pop = 1'b0;
  logic [7:0] out_read_glyph;
  logic [7:0] out_read_attr;
  logic       out_read_valid;

  logic [15:0] screen_img [0:CELL_COUNT-1];
  cell_read_t  expected_cells [$];
  int          error_count = 0;
  int          cycle_count = 0;
  int          pop_hold = 0;
  bit          steady = 1'b1;

  text_cell_rect_draw_engine #(
    .SCREEN_COLUMNS(COLS),
    .SCREEN_ROWS(ROWS)
  ) u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_push(in_push),
    .in_full(in_full),
    .in_command(in_command),
    .in_col_x(in_col_x),
    .in_row_y(in_row_y),
    .in_width(in_width),
    .in_height(in_height),
    .in_ink_color(in_ink_color),
    .in_paper_color(in_paper_color),
    .in_glyph(in_glyph),
    .in_visible(in_visible),
    .out_empty(out_empty),
    .out_pop(out_pop),
    .out_read_glyph(out_read_glyph),
    .out_read_attr(out_read_attr),
    .out_read_valid(out_read_valid)
  );

  always #5 clk = ~clk;

  function automatic void store_cell(int col, int row, logic [7:0] g, logic [7:0] a);
    if (col < COLS && row < ROWS) begin
      screen_img[row * COLS + col] = {a, g};
    end
  endfunction

  function automatic void paint_area(int x, int y, int w, int h, logic [7:0] a);
    for (int r = y; r < y + h && r < ROWS; r++) begin
      for (int c = x; c < x + w && c < COLS; c++) begin
        store_cell(c, r, GL_SPACE, a);
      end
    end
  endfunction

  function automatic void paint_outline(int x, int y, int w, int h, logic [7:0] a);
    int xr;
    int yb;
    if (w < 2 || h < 2) begin
      return;
    end
    xr = x + w - 1;
    yb = y + h - 1;
    for (int c = x + 1; c < xr && c < COLS; c++) begin
      store_cell(c, y, GL_HORIZ, a);
      store_cell(c, yb, GL_HORIZ, a);
    end
    for (int r = y + 1; r < yb && r < ROWS; r++) begin
      store_cell(x, r, GL_VERT, a);
      store_cell(xr, r, GL_VERT, a);
    end
    store_cell(x, y, GL_TOP_LEFT, a);
    store_cell(xr, y, GL_TOP_RIGHT, a);
    store_cell(x, yb, GL_BOT_LEFT, a);
    store_cell(xr, yb, GL_BOT_RIGHT, a);
  endfunction

  function automatic cell_read_t apply_draw(logic [2:0] cmd, logic [7:0] x, logic [7:0] y,
                                            logic [7:0] w, logic [7:0] h, logic [3:0] fg,
                                            logic [3:0] bg, logic [7:0] gl, logic vis);
    cell_read_t res;
    int xi;
    int yi;
    int wi;
    int hi;
    res = '{glyph: 8'd0, attr: 8'd0, valid: 1'b0};
    xi = int'(x);
    yi = int'(y);
    wi = int'(w);
    hi = int'(h);
    case (cmd)
      CMD_CLEAR: paint_area(xi, yi, wi, hi, {4'd0, fg});
      CMD_FILL: paint_area(xi, yi, wi, hi, {fg, fg});
      CMD_OUTLINE: paint_outline(xi, yi, wi, hi, {4'd0, fg});
      CMD_SHADOW: begin
        paint_outline(xi, yi, wi, hi, {4'd0, fg});
        for (int r = yi + 1; r <= yi + hi && r < ROWS; r++) begin
          store_cell(xi + wi, r, GL_SHADE, ATTR_SHADOW);
        end
        for (int c = xi + 1; c <= xi + wi && c < COLS; c++) begin
          store_cell(c, yi + hi, GL_SHADE, ATTR_SHADOW);
        end
      end
      CMD_PUT: store_cell(xi, yi, gl, {bg, fg});
      CMD_CURSOR: store_cell(xi, yi, vis ? GL_BLOCK : GL_SPACE, ATTR_CURSOR);
      CMD_READ: begin
        if (xi < COLS && yi < ROWS) begin
          res.glyph = screen_img[yi * COLS + xi][7:0];
          res.attr = screen_img[yi * COLS + xi][15:8];
          res.valid = 1'b1;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic int idle_len();
    if ($urandom_range(99) < 85) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 150);
  endfunction

  task automatic send_cmd(input logic [2:0] cmd, input logic [7:0] x, input logic [7:0] y,
                          input logic [7:0] w, input logic [7:0] h, input logic [3:0] fg,
                          input logic [3:0] bg, input logic [7:0] gl, input logic vis);
    int gap;
    in_push <= 1'b1;
    in_command <= cmd;
    in_col_x <= x;
    in_row_y <= y;
    in_width <= w;
    in_height <= h;
    in_ink_color <= fg;
    in_paper_color <= bg;
    in_glyph <= gl;
    in_visible <= vis;
    do @(posedge clk); while (in_full);
    expected_cells.push_back(apply_draw(cmd, x, y, w, h, fg, bg, gl, vis));
    gap = (steady || $urandom_range(2) != 0) ? 0 : idle_len();
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_rect(input logic [2:0] cmd, input logic [7:0] x, input logic [7:0] y,
                           input logic [7:0] w, input logic [7:0] h, input logic [3:0] fg);
    send_cmd(cmd, x, y, w, h, fg, 4'd0, 8'd0, 1'b0);
  endtask

  task automatic send_read(input logic [7:0] x, input logic [7:0] y);
    send_cmd(CMD_READ, x, y, 8'd0, 8'd0, 4'd0, 4'd0, 8'd0, 1'b0);
  endtask

  always @(posedge clk) begin
    cell_read_t exp_cell;
    if (rst_n && out_pop && !out_empty) begin
      if (expected_cells.size() == 0) begin
        $display("%0t: result beat with none expected: glyph %h attr %h valid %b",
                 $time, out_read_glyph, out_read_attr, out_read_valid);
        error_count++;
      end else begin
        exp_cell = expected_cells.pop_front();
        if (out_read_glyph !== exp_cell.glyph) begin
          $display("%0t: read_glyph expected %h actual %h", $time, exp_cell.glyph,
                   out_read_glyph);
          error_count++;
        end
        if (out_read_attr !== exp_cell.attr) begin
          $display("%0t: read_attr expected %h actual %h", $time, exp_cell.attr,
                   out_read_attr);
          error_count++;
        end
        if (out_read_valid !== exp_cell.valid) begin
          $display("%0t: read_valid expected %b actual %b", $time, exp_cell.valid,
                   out_read_valid);
          error_count++;
        end
      end
    end
    if (pop_hold > 0) begin
      out_pop <= 1'b0;
      pop_hold = pop_hold - 1;
    end else begin
      out_pop <= 1'b1;
      if (!steady && $urandom_range(5) == 0) begin
        pop_hold = idle_len();
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic test_power_on_state();
    send_read(8'd0, 8'd0);
    send_read(8'd79, 8'd24);
    send_read(8'd80, 8'd24);
    send_read(8'd79, 8'd25);
    send_read(8'd255, 8'd255);
  endtask

  task automatic test_area_fill();
    send_rect(CMD_FILL, 8'd0, 8'd0, 8'd255, 8'd255, 4'd15);
    send_read(8'd40, 8'd12);
    send_rect(CMD_CLEAR, 8'd70, 8'd20, 8'd255, 8'd255, 4'd0);
    send_read(8'd79, 8'd24);
    send_rect(CMD_FILL, 8'd5, 8'd5, 8'd0, 8'd3, 4'd9);
    send_read(8'd5, 8'd5);
  endtask

  task automatic test_box_shapes();
    send_rect(CMD_OUTLINE, 8'd10, 8'd5, 8'd2, 8'd2, 4'd5);
    send_read(8'd11, 8'd6);
    send_rect(CMD_OUTLINE, 8'd30, 8'd5, 8'd1, 8'd6, 4'd6);
    send_rect(CMD_OUTLINE, 8'd78, 8'd23, 8'd5, 8'd5, 4'd12);
    send_read(8'd78, 8'd23);
    send_rect(CMD_SHADOW, 8'd20, 8'd10, 8'd1, 8'd3, 4'd3);
    send_read(8'd21, 8'd11);
    send_rect(CMD_SHADOW, 8'd76, 8'd22, 8'd4, 8'd2, 4'd10);
    send_read(8'd79, 8'd24);
  endtask

  task automatic test_single_cells();
    send_cmd(CMD_PUT, 8'd79, 8'd24, 8'd0, 8'd0, 4'd15, 4'd15, 8'd255, 1'b0);
    send_read(8'd79, 8'd24);
    send_cmd(CMD_PUT, 8'd80, 8'd0, 8'd0, 8'd0, 4'd7, 4'd1, 8'h41, 1'b0);
    send_cmd(CMD_CURSOR, 8'd0, 8'd0, 8'd0, 8'd0, 4'd0, 4'd0, 8'd0, 1'b1);
    send_cmd(CMD_CURSOR, 8'd1, 8'd0, 8'd0, 8'd0, 4'd0, 4'd0, 8'd0, 1'b0);
    send_read(8'd0, 8'd0);
    send_cmd(CMD_UNUSED, 8'd255, 8'd255, 8'd255, 8'd255, 4'd15, 4'd15, 8'd255, 1'b1);
  endtask

  task automatic test_random_mix();
    logic [2:0] cmd;
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] w;
    logic [7:0] h;
    logic [7:0] last_x;
    logic [7:0] last_y;
    logic [7:0] last_w;
    logic [7:0] last_h;
    int pick;
    last_x = 8'd0;
    last_y = 8'd0;
    last_w = 8'd4;
    last_h = 8'd4;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 50 == 0) begin
        steady = ($urandom_range(3) == 0);
      end
      pick = $urandom_range(99);
      x = 8'($urandom_range(79));
      y = 8'($urandom_range(24));
      w = 8'($urandom_range(12));
      h = 8'($urandom_range(8));
      if ($urandom_range(9) == 0) begin
        x = 8'($urandom_range(255));
        y = 8'($urandom_range(255));
      end
      if ($urandom_range(9) == 0) begin
        w = 8'($urandom_range(255));
        h = 8'($urandom_range(255));
      end
      if (pick < 35) begin
        cmd = CMD_READ;
        if (pick < 20) begin
          x = last_x + 8'($urandom_range(last_w));
          y = last_y + 8'($urandom_range(last_h));
        end
      end else if (pick < 43) begin
        cmd = CMD_CLEAR;
      end else if (pick < 51) begin
        cmd = CMD_FILL;
      end else if (pick < 63) begin
        cmd = CMD_OUTLINE;
      end else if (pick < 75) begin
        cmd = CMD_SHADOW;
      end else if (pick < 87) begin
        cmd = CMD_PUT;
      end else if (pick < 97) begin
        cmd = CMD_CURSOR;
      end else begin
        cmd = CMD_UNUSED;
      end
      if (cmd != CMD_READ) begin
        last_x = x;
        last_y = y;
        last_w = w;
        last_h = h;
      end
      send_cmd(cmd, x, y, w, h, 4'($urandom_range(15)), 4'($urandom_range(15)),
               8'($urandom_range(255)), 1'($urandom_range(1)));
    end
    steady = 1'b1;
  endtask

  initial begin
    for (int i = 0; i < CELL_COUNT; i++) begin
      screen_img[i] = 16'h0000;
    end
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    test_power_on_state();
    test_area_fill();
    test_box_shapes();
    test_single_cells();
    test_random_mix();
    in_push <= 1'b0;
    while (expected_cells.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
